// ===== rtl/core/stoi_pkg.sv =====
// shared types, character codes and digit decode for the string parser
package stoi_pkg;

    localparam int RADIX_W = 6;
    localparam int DIGIT_W = 6;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_A_UP  = 8'h41;

    // bases
    localparam logic [RADIX_W-1:0] BASE_AUTO  = 6'd0;
    localparam logic [RADIX_W-1:0] BASE_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] BASE_OCT   = 6'd8;
    localparam logic [RADIX_W-1:0] BASE_DEC   = 6'd10;
    localparam logic [RADIX_W-1:0] BASE_HEX   = 6'd16;
    localparam logic [RADIX_W-1:0] BASE_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RST  = BASE_DEC;

    // marks a character that is no digit in any base
    localparam logic [DIGIT_W-1:0] DIGIT_NONE = 6'd63;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    typedef enum logic [5:0] {
        PH_SKIP    = 6'b000001,
        PH_SIGNED  = 6'b000010,
        PH_ZERO    = 6'b000100,
        PH_XSEEN   = 6'b001000,
        PH_DIGITS  = 6'b010000,
        PH_STOPPED = 6'b100000
    } t_phase;

    // value of a character as a digit, DIGIT_NONE when it is none
    function automatic logic [DIGIT_W-1:0] digit_of(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        if (c inside {[8'h30:8'h39]}) begin
            t = c - CH_ZERO;
        end else if (c inside {[8'h61:8'h7A]}) begin
            t = c - CH_A_LO + 8'd10;
        end else if (c inside {[8'h41:8'h5A]}) begin
            t = c - CH_A_UP + 8'd10;
        end else begin
            t = {2'b00, DIGIT_NONE};
        end
        return t[DIGIT_W-1:0];
    endfunction

    // base 0 (automatic) or 2..36
    function automatic logic base_ok(input logic [RADIX_W-1:0] b);
        return (b == BASE_AUTO) || (b >= BASE_MIN && b <= BASE_MAX);
    endfunction

endpackage

// ===== rtl/core/stoi_in_if.sv =====
// character channel of the string parser
interface stoi_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

// ===== rtl/core/stoi_out_if.sv =====
// result channel of the string parser
interface stoi_out_if import stoi_pkg::*; #(parameter int POS_W = 13);
    logic             valid;
    logic             ready;
    logic [63:0]      value;
    t_status          status;
    logic [POS_W-1:0] end_index;
    logic             stopped_early;

    modport source (output valid, output value, output status, output end_index,
                    output stopped_early, input ready);
    modport sink   (input valid, input value, input status, input end_index,
                    input stopped_early, output ready);
endinterface

// ===== rtl/core/stoi_mac.sv =====
// accumulator multiply-add by base with exact signed 64-bit limit check
module stoi_mac import stoi_pkg::*; (
    input  logic [63:0]        i_acc,
    input  logic [RADIX_W-1:0] i_base,
    input  logic [DIGIT_W-1:0] i_digit,
    input  logic               i_neg,
    output logic [63:0]        o_sum,
    output logic               o_ovf
);

    localparam int PROD_W = 64 + RADIX_W;

    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] limit;

    // acc * base + digit, wide enough to never wrap
    assign prod  = PROD_W'(i_acc) * PROD_W'(i_base) + PROD_W'(i_digit);

    // magnitude limit: 2^63 for negative numbers, 2^63 - 1 otherwise
    assign limit = i_neg ? PROD_W'(64'h8000_0000_0000_0000)
                         : PROD_W'(64'h7FFF_FFFF_FFFF_FFFF);

    assign o_ovf = prod > limit;
    assign o_sum = prod[63:0];

endmodule

// ===== rtl/core/string_to_integer_parser_unit.sv =====
// string to signed 64-bit integer parser, one character per cycle
//
// Usage: characters stream in on i_in (valid/ready), one word per character,
// and a zero character ends the string. At the terminator one result word
// goes out on o_out: value, status (ok, invalid, range), end_index and
// stopped_early. The radix register is written through i_cfg_wr_en and
// i_cfg_wr_data; it is sampled at the first non-space character of a string.
// Throughput: one character per cycle unless a terminator waits on a pending result,
// set by the single 64x6 multiply-add and limit compare that updates the accumulator
// for each digit. A character is registered at acceptance and processed from the
// input register; the terminator, once processed, loads the result register that
// drives o_out.
// Stall: the result register holds a word until it is taken, and characters
// of the next string keep flowing meanwhile; only a second terminator that
// meets a still pending result holds i_in.ready low.
// Reset (synchronous, active low): radix returns to 10, parser state clears
// and both channel registers empty.
module string_to_integer_parser_unit import stoi_pkg::*; #(
    parameter int MAX_LEN = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [RADIX_W-1:0] i_cfg_wr_data,
    stoi_in_if.sink            i_in,
    stoi_out_if.source         o_out
);

    localparam int              POS_W   = $clog2(MAX_LEN + 1);
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LEN);

    // configuration
    logic [RADIX_W-1:0] r_radix;

    // input register
    logic               r_ch_vld;
    logic [7:0]         r_ch;

    // parser state
    t_phase             r_phase,  n_phase;
    logic               r_neg,    n_neg;
    logic [RADIX_W-1:0] r_wb,     n_wb;
    logic [63:0]        r_acc,    n_acc;
    logic               r_rerr,   n_rerr;
    logic               r_dseen,  n_dseen;
    logic [POS_W-1:0]   r_pos,    n_pos;
    logic [POS_W-1:0]   r_stop,   n_stop;

    // result register
    logic               r_out_vld;
    logic [63:0]        r_out_value, n_out_value;
    t_status            r_out_status, n_out_status;
    logic [POS_W-1:0]   r_out_end, n_out_end;
    logic               r_out_early, n_out_early;

    logic               advance;
    logic               emit;
    logic [RADIX_W-1:0] eb_raw;
    logic [RADIX_W-1:0] eb;
    logic               is_first;
    logic               zero_case;
    logic [DIGIT_W-1:0] dig;
    logic [63:0]        mac_sum;
    logic               mac_ovf;
    logic [POS_W-1:0]   pos_inc;
    logic [RADIX_W-1:0] eff_base;

    // handshake: a terminator waits only while a result is still pending
    assign advance     = r_ch_vld && ((r_ch != CH_NUL) || !r_out_vld || o_out.ready);
    assign emit        = advance && (r_ch == CH_NUL);
    assign i_in.ready  = !r_ch_vld || advance;

    // base seen by this character and digit decode
    assign is_first  = (r_phase == PH_SKIP) || (r_phase == PH_SIGNED);
    assign eb_raw    = (r_phase == PH_SKIP) ? r_radix : r_wb;
    assign zero_case = is_first && (r_ch == CH_ZERO)
                       && ((eb_raw == BASE_AUTO) || (eb_raw == BASE_HEX));
    assign dig       = digit_of(r_ch);
    assign pos_inc   = (r_pos == MAX_POS) ? r_pos : r_pos + POS_W'(1);
    assign eff_base  = r_wb;

    always_comb begin
        if (is_first && eb_raw == BASE_AUTO) begin
            eb = BASE_DEC;
        end else if (r_phase == PH_ZERO && eb_raw == BASE_AUTO) begin
            eb = BASE_OCT;
        end else begin
            eb = eb_raw;
        end
    end

    stoi_mac u_mac (
        .i_acc   (r_acc),
        .i_base  (eb),
        .i_digit (dig),
        .i_neg   (r_neg),
        .o_sum   (mac_sum),
        .o_ovf   (mac_ovf)
    );

    // parser next state
    always_comb begin
        logic take_first;
        logic take;
        take_first = 1'b0;
        take       = 1'b0;
        n_phase    = r_phase;
        n_neg      = r_neg;
        n_wb       = r_wb;
        n_acc      = r_acc;
        n_rerr     = r_rerr;
        n_dseen    = r_dseen;
        n_pos      = r_pos;
        n_stop     = r_stop;
        if (advance) begin
            if (r_ch == CH_NUL) begin
                n_phase = PH_SKIP;
                n_neg   = 1'b0;
                n_wb    = BASE_AUTO;
                n_acc   = 64'd0;
                n_rerr  = 1'b0;
                n_dseen = 1'b0;
                n_pos   = '0;
                n_stop  = '0;
            end else begin
                n_pos = pos_inc;
                case (r_phase)
                    PH_SKIP: begin
                        if (r_ch != CH_SPACE) begin
                            n_wb = r_radix;
                            if (!base_ok(r_radix)) begin
                                n_phase = PH_STOPPED;
                            end else if (r_ch == CH_PLUS) begin
                                n_phase = PH_SIGNED;
                            end else if (r_ch == CH_MINUS) begin
                                n_neg   = 1'b1;
                                n_phase = PH_SIGNED;
                            end else begin
                                take_first = 1'b1;
                            end
                        end
                    end
                    PH_SIGNED: begin
                        take_first = 1'b1;
                    end
                    PH_ZERO: begin
                        if (r_ch == CH_X_LO || r_ch == CH_X_UP) begin
                            n_wb    = BASE_HEX;
                            n_phase = PH_XSEEN;
                        end else begin
                            take = 1'b1;
                        end
                    end
                    PH_XSEEN, PH_DIGITS: begin
                        take = 1'b1;
                    end
                    default: begin
                    end
                endcase
                // a leading zero in hex or automatic base may start a prefix
                if (take_first) begin
                    if (zero_case) begin
                        n_wb    = eb_raw;
                        n_dseen = 1'b1;
                        n_acc   = 64'd0;
                        n_stop  = pos_inc;
                        n_phase = PH_ZERO;
                    end else begin
                        take = 1'b1;
                    end
                end
                // one digit: accumulate or stop
                if (take) begin
                    n_wb = eb;
                    if (dig >= eb) begin
                        n_phase = PH_STOPPED;
                    end else begin
                        if (!r_rerr) begin
                            if (mac_ovf) begin
                                n_rerr = 1'b1;
                            end else begin
                                n_acc = mac_sum;
                            end
                        end
                        n_dseen = 1'b1;
                        n_stop  = pos_inc;
                        n_phase = PH_DIGITS;
                    end
                end
            end
        end
    end

    // result word formed at the terminator
    always_comb begin
        logic [RADIX_W-1:0] b;
        b            = (r_phase == PH_SKIP) ? r_radix : eff_base;
        n_out_value  = 64'd0;
        n_out_status = ST_INVALID;
        n_out_end    = '0;
        n_out_early  = 1'b0;
        if (base_ok(b)) begin
            n_out_early = (r_phase == PH_STOPPED) || (r_phase == PH_XSEEN);
            if (!r_dseen) begin
                n_out_status = ST_INVALID;
            end else if (r_rerr) begin
                n_out_status = ST_RANGE;
                n_out_end    = r_stop;
            end else begin
                n_out_status = ST_OK;
                n_out_end    = r_stop;
                n_out_value  = r_neg ? (64'd0 - r_acc) : r_acc;
            end
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RST;
        end else if (i_cfg_wr_en) begin
            r_radix <= i_cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_ch_vld <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_ch <= i_in.ch;
        end
    end

    // parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP;
            r_neg   <= 1'b0;
            r_wb    <= BASE_AUTO;
            r_acc   <= 64'd0;
            r_rerr  <= 1'b0;
            r_dseen <= 1'b0;
            r_pos   <= '0;
            r_stop  <= '0;
        end else begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_wb    <= n_wb;
            r_acc   <= n_acc;
            r_rerr  <= n_rerr;
            r_dseen <= n_dseen;
            r_pos   <= n_pos;
            r_stop  <= n_stop;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (emit) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
        if (emit) begin
            r_out_value  <= n_out_value;
            r_out_status <= n_out_status;
            r_out_end    <= n_out_end;
            r_out_early  <= n_out_early;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.value         = r_out_value;
    assign o_out.status        = r_out_status;
    assign o_out.end_index     = r_out_end;
    assign o_out.stopped_early = r_out_early;

`ifndef SYNTH
    // a pending result is never overwritten by the next terminator
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ch_vld && r_ch == CH_NUL && r_out_vld && !o_out.ready) |-> !i_in.ready)
        else $error("terminator advanced over a pending result");

    // every terminator leaves the parser cleared for the next string
    a_clear_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_phase == PH_SKIP && r_pos == '0 && !r_dseen && !r_rerr))
        else $error("parser state not cleared after terminator");

    // only an ok result carries a nonzero value
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ST_OK) |-> (o_out.value == 64'd0))
        else $error("nonzero value with error status");

    // an invalid conversion always reports position zero
    a_invalid_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == ST_INVALID) |-> (o_out.end_index == '0))
        else $error("invalid result with nonzero end index");
`endif

endmodule

// ===== tb/tb_string_to_integer_parser_unit.sv =====
// testbench for the string to integer parser: directed and random strings against a predictor
module tb_string_to_integer_parser_unit;
    import stoi_pkg::*;

    localparam int          MAX_LEN       = 4096;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          CYCLE_LIMIT   = 500000;
    localparam int unsigned REPORT_LIMIT  = 10;

    // one converted string as it leaves the block
    typedef struct packed {
        logic [63:0] value;
        t_status     status;
        logic [12:0] end_index;
        logic        stopped_early;
    } t_conversion;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [RADIX_W-1:0] i_cfg_wr_data;

    stoi_in_if              in_bus ();
    stoi_out_if #(.POS_W(13)) out_bus ();

    string_to_integer_parser_unit #(.MAX_LEN(MAX_LEN)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_bus.sink),
        .o_out         (out_bus.source)
    );

    // parser shadow state
    logic [RADIX_W-1:0] radix_shadow;
    t_phase             ps_phase;
    logic               ps_neg;
    logic [RADIX_W-1:0] ps_base;
    logic [63:0]        ps_acc;
    logic               ps_range;
    logic               ps_digit;
    int unsigned        ps_pos;
    int unsigned        ps_stop;

    t_conversion expected_conversions[$];
    int unsigned mismatch_count = 0;
    int unsigned chars_sent     = 0;
    int unsigned src_idle_pct   = 0;
    int unsigned sink_idle_pct  = 0;
    int          cycle_count    = 0;

    // clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result receiver backpressure
    always @(negedge i_clk) begin
        out_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    function automatic int unsigned char_digit(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_ZERO + 8'd9) return 32'(c - CH_ZERO);
        if (c >= CH_A_LO && c <= CH_A_LO + 8'd25) return c - CH_A_LO + 10;
        if (c >= CH_A_UP && c <= CH_A_UP + 8'd25) return c - CH_A_UP + 10;
        return 99;
    endfunction

    function automatic logic radix_usable(input logic [RADIX_W-1:0] b);
        return (b == BASE_AUTO) || (b >= BASE_MIN && b <= BASE_MAX);
    endfunction

    function automatic int unsigned sat_inc(input int unsigned p);
        return (p + 1 > MAX_LEN) ? MAX_LEN : p + 1;
    endfunction

    function automatic void clear_parse();
        ps_phase = PH_SKIP;
        ps_neg   = 1'b0;
        ps_base  = '0;
        ps_acc   = '0;
        ps_range = 1'b0;
        ps_digit = 1'b0;
        ps_pos   = 0;
        ps_stop  = 0;
    endfunction

    // digit in the working base: accumulate with exact overflow test, or stop
    function automatic void accept_digit(input logic [7:0] c, input int unsigned p);
        logic [63:0] dv;
        logic [63:0] bv;
        logic [63:0] lim;
        dv = 64'(char_digit(c));
        bv = 64'(ps_base);
        if (dv >= bv) begin
            ps_phase = PH_STOPPED;
            return;
        end
        if (!ps_range) begin
            lim = ps_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            if (ps_acc > (lim - dv) / bv) ps_range = 1'b1;
            else ps_acc = ps_acc * bv + dv;
        end
        ps_digit = 1'b1;
        ps_stop  = sat_inc(p);
        ps_phase = PH_DIGITS;
    endfunction

    // first character after spaces and sign; a leading zero may open a prefix
    function automatic void first_char(input logic [7:0] c, input int unsigned p);
        if (c == CH_ZERO && (ps_base == BASE_AUTO || ps_base == BASE_HEX)) begin
            ps_digit = 1'b1;
            ps_acc   = '0;
            ps_stop  = sat_inc(p);
            ps_phase = PH_ZERO;
            return;
        end
        if (ps_base == BASE_AUTO) ps_base = BASE_DEC;
        accept_digit(c, p);
    endfunction

    // advance the shadow parser by one accepted character
    function automatic void advance_parser(input logic [7:0] c);
        int unsigned        p;
        logic [RADIX_W-1:0] eff;
        t_conversion        r;
        p = ps_pos;
        if (c == CH_NUL) begin
            eff = (ps_phase == PH_SKIP) ? radix_shadow : ps_base;
            r.value         = '0;
            r.end_index     = '0;
            r.stopped_early = 1'b0;
            if (!radix_usable(eff)) begin
                r.status = ST_INVALID;
            end else begin
                r.stopped_early = (ps_phase == PH_STOPPED) || (ps_phase == PH_XSEEN);
                if (!ps_digit) begin
                    r.status = ST_INVALID;
                end else if (ps_range) begin
                    r.status    = ST_RANGE;
                    r.end_index = 13'(ps_stop);
                end else begin
                    r.status    = ST_OK;
                    r.end_index = 13'(ps_stop);
                    r.value     = ps_neg ? 64'd0 - ps_acc : ps_acc;
                end
            end
            expected_conversions.push_back(r);
            clear_parse();
            return;
        end
        ps_pos = sat_inc(p);
        case (ps_phase)
            PH_SKIP: begin
                if (c != CH_SPACE) begin
                    ps_base = radix_shadow;
                    if (!radix_usable(ps_base)) begin
                        ps_phase = PH_STOPPED;
                    end else if (c == CH_PLUS) begin
                        ps_phase = PH_SIGNED;
                    end else if (c == CH_MINUS) begin
                        ps_neg   = 1'b1;
                        ps_phase = PH_SIGNED;
                    end else begin
                        first_char(c, p);
                    end
                end
            end
            PH_SIGNED: begin
                first_char(c, p);
            end
            PH_ZERO: begin
                if (c == CH_X_LO || c == CH_X_UP) begin
                    ps_base  = BASE_HEX;
                    ps_phase = PH_XSEEN;
                end else begin
                    if (ps_base == BASE_AUTO) ps_base = BASE_OCT;
                    accept_digit(c, p);
                end
            end
            PH_XSEEN, PH_DIGITS: begin
                accept_digit(c, p);
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void note_mismatch(input string field, input logic [63:0] want,
                                          input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%s mismatch: expected %0h actual %0h", field, want, got);
    endfunction

    // compare each result word with the oldest expected conversion
    always @(posedge i_clk) begin : result_check
        t_conversion want;
        if (i_rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
            if (expected_conversions.size() == 0) begin
                note_mismatch("unexpected word, value", 64'd0, out_bus.value);
            end else begin
                want = expected_conversions.pop_front();
                if (out_bus.value !== want.value)
                    note_mismatch("value", want.value, out_bus.value);
                if (out_bus.status !== want.status)
                    note_mismatch("status", 64'(want.status), 64'(out_bus.status));
                if (out_bus.end_index !== want.end_index)
                    note_mismatch("end_index", 64'(want.end_index), 64'(out_bus.end_index));
                if (out_bus.stopped_early !== want.stopped_early)
                    note_mismatch("stopped_early", 64'(want.stopped_early),
                                  64'(out_bus.stopped_early));
            end
        end
    end

    // send one character word; entered and left at a falling edge
    task automatic send_char(input logic [7:0] c);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_bus.valid <= 1'b1;
        in_bus.ch    <= c;
        @(posedge i_clk);
        while (in_bus.ready !== 1'b1) @(posedge i_clk);
        advance_parser(c);
        chars_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_seq(input logic [7:0] q[$]);
        foreach (q[i]) send_char(q[i]);
        send_char(CH_NUL);
    endtask

    task automatic send_text(input string s);
        logic [7:0] q[$];
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        send_seq(q);
    endtask

    // stop sending until every conversion is out and the block has gone quiet
    task automatic hold_until_drained();
        in_bus.valid <= 1'b0;
        while (expected_conversions.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_radix(input logic [RADIX_W-1:0] r);
        hold_until_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= r;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        radix_shadow = r;
    endtask

    function automatic logic [7:0] digit_char(input int unsigned v);
        if (v < 10) return CH_ZERO + 8'(v);
        return ($urandom_range(1) ? CH_A_LO : CH_A_UP) + 8'(v - 10);
    endfunction

    // mostly well-formed numbers with random content, some noise and junk tails
    task automatic send_random_string();
        logic [7:0]  q[$];
        logic [7:0]  digs[$];
        logic [63:0] mag;
        int unsigned base;
        int unsigned n;
        if ($urandom_range(99) < 12) begin
            n = $urandom_range(12);
            repeat (n) q.push_back(8'($urandom_range(255, 1)));
            send_seq(q);
            return;
        end
        n = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
        repeat (n) q.push_back(CH_SPACE);
        case ($urandom_range(2))
            1: q.push_back(CH_PLUS);
            2: q.push_back(CH_MINUS);
            default: begin
            end
        endcase
        if ($urandom_range(15) == 0) q.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
        base = 32'(radix_shadow);
        if (radix_shadow == BASE_AUTO) begin
            case ($urandom_range(2))
                0: base = 32'(BASE_DEC);
                1: begin
                    q.push_back(CH_ZERO);
                    base = 32'(BASE_OCT);
                end
                default: begin
                    q.push_back(CH_ZERO);
                    q.push_back($urandom_range(1) ? CH_X_LO : CH_X_UP);
                    base = 32'(BASE_HEX);
                end
            endcase
        end else if (radix_shadow == BASE_HEX && $urandom_range(1)) begin
            q.push_back(CH_ZERO);
            q.push_back($urandom_range(1) ? CH_X_LO : CH_X_UP);
        end
        if (!radix_usable(6'(base))) base = 32'(BASE_DEC);
        if ($urandom_range(7) == 0) q.push_back(CH_ZERO);
        case ($urandom_range(3))
            0: mag = 64'($urandom_range(1000));
            1: mag = {$urandom, $urandom} >> $urandom_range(63);
            // around the signed limits
            2: mag = 64'h8000_0000_0000_0000 - 64'd2 + 64'($urandom_range(3));
            default: mag = {$urandom, $urandom};
        endcase
        if (mag == 0) digs.push_back(CH_ZERO);
        while (mag != 0) begin
            digs.push_front(digit_char(int'(mag % 64'(base))));
            mag = mag / 64'(base);
        end
        foreach (digs[i]) q.push_back(digs[i]);
        if ($urandom_range(9) == 0) begin
            n = $urandom_range(4, 1);
            repeat (n) q.push_back(digit_char($urandom_range(base - 1)));
        end
        if ($urandom_range(4) == 0) begin
            n = $urandom_range(3, 1);
            repeat (n) q.push_back(8'($urandom_range(255, 1)));
        end
        send_seq(q);
    endtask

    // decimal extremes, signs, empty and broken strings
    task automatic test_decimal_strings();
        set_radix(BASE_DEC);
        send_text("0");
        send_text(" -42");
        send_text("+7");
        send_text("9223372036854775807");
        send_text("-9223372036854775808");
        send_text("9223372036854775808");
        send_text("-9223372036854775809z");
        send_text("");
        send_text("-");
        send_text("  ");
        send_text("abc");
        send_text("12z3");
    endtask

    // hex prefix handling and automatic base
    task automatic test_prefix_and_auto();
        set_radix(BASE_HEX);
        send_text("0x1F");
        send_text("0X");
        send_text("-0x8000000000000000");
        set_radix(BASE_AUTO);
        send_text("0x7f");
        send_text("017");
        send_text("08");
        send_text("0xg");
    endtask

    // smallest and largest bases, and the invalid ones
    task automatic test_radix_extremes();
        set_radix(BASE_MIN);
        send_text("-1012");
        set_radix(BASE_MAX);
        send_text("zZ");
        set_radix(6'd1);
        send_text("1");
        set_radix(6'd63);
        send_text(" 5");
        set_radix(6'd37);
        send_text("");
    endtask

    // non-ascii bytes and other characters that are never digits
    task automatic test_odd_characters();
        logic [7:0] q[$];
        set_radix(BASE_DEC);
        q.push_back(8'h80);
        q.push_back(CH_ZERO + 8'd1);
        send_seq(q);
        q.delete();
        q.push_back(CH_ZERO + 8'd4);
        q.push_back(8'hFF);
        send_seq(q);
        send_text("1 2");
    endtask

    // positions saturate on strings longer than the position range
    task automatic test_saturation();
        logic [7:0] q[$];
        set_radix(BASE_DEC);
        repeat (MAX_LEN + 4) q.push_back(CH_ZERO);
        send_seq(q);
        q.delete();
        repeat (MAX_LEN - 2) q.push_back(CH_SPACE);
        q.push_back(CH_ZERO + 8'd1);
        q.push_back(CH_ZERO + 8'd2);
        send_seq(q);
        q.delete();
        repeat (MAX_LEN + 100) q.push_back(CH_SPACE);
        q.push_back(CH_ZERO + 8'd7);
        send_seq(q);
    endtask

    task automatic test_random_traffic(input int unsigned src_pct, input int unsigned sink_pct,
                                       input int unsigned quota);
        int unsigned start;
        int unsigned strings;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        start   = chars_sent;
        strings = 0;
        while (chars_sent - start < quota) begin
            // new radix every few strings, written while the block is quiet
            if (strings % 10 == 0) begin
                case ($urandom_range(9))
                    0, 1: set_radix(BASE_AUTO);
                    2: set_radix($urandom_range(1) ? BASE_MIN : BASE_MAX);
                    3: set_radix($urandom_range(1) ? BASE_DEC : BASE_HEX);
                    4: set_radix(6'($urandom_range(63)));
                    default: set_radix(6'($urandom_range(36, 2)));
                endcase
            end
            send_random_string();
            strings++;
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        in_bus.valid  = 1'b0;
        in_bus.ch     = '0;
        out_bus.ready = 1'b0;
        radix_shadow  = RADIX_RST;
        clear_parse();
        src_idle_pct  = 34;
        sink_idle_pct = 53;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_decimal_strings();
        test_prefix_and_auto();
        test_radix_extremes();
        test_odd_characters();
        test_saturation();
        test_random_traffic(34, 53, 550);
        test_random_traffic(53, 34, 550);
        test_random_traffic(0, 0, 550);

        hold_until_drained();
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
